/* rtl/core/samrd_pkg.sv */
// ----------------------------------------------------------------------------
// Shift-add multiplier and restoring divider package
// Operation codes and the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package samrd_pkg;

    localparam int unsigned FieldWidth = 32;

    typedef enum logic
    {
        KIND_MUL = 1'b0,
        KIND_DIV = 1'b1
    } samrd_kind_t;

    typedef struct packed
    {
        logic        valid;
        samrd_kind_t kind;
        logic        neg;
    } samrd_ctl_t;

endpackage

/* rtl/core/shift_add_mul_restoring_div.sv */
// ----------------------------------------------------------------------------
// Shift-add multiplier and restoring divider
// Signed multiply or unsigned divide, pipelined one transfer per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata {operand_b, operand_a}, tuser kind
// m_axis    out  tdata {result_high, result_low}
//
// A transfer can be taken every cycle while the output is not stalled; each result
// passes the input register and then one register stage per quotient bit.
// The multiply uses stages one and two and is carried along after that.
// Reset empties the pipeline; a stall on the output holds every stage.
module shift_add_mul_restoring_div
    import samrd_pkg::*;
#(
    parameter int unsigned WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result_low, result_high
);

    samrd_ctl_t         ctl   [0:WIDTH];
    logic [WIDTH-1:0]   quo   [0:WIDTH];
    logic [WIDTH-1:0]   dvs   [0:WIDTH];
    logic [WIDTH-1:0]   rem   [0:WIDTH];
    logic [2*WIDTH-1:0] prod_reg [1:WIDTH];

    samrd_ctl_t       ctl0_reg;
    logic [WIDTH-1:0] quo0_reg;
    logic [WIDTH-1:0] dvs0_reg;
    logic [WIDTH-1:0] mag_a_reg;
    logic [WIDTH-1:0] mag_b_reg;
    logic             adv;
    logic [WIDTH-1:0] in_a;
    logic [WIDTH-1:0] in_b;
    samrd_ctl_t       ctl0_next;
    logic [WIDTH-1:0] low_res;
    logic [WIDTH-1:0] high_res;
    logic [FieldWidth-1:0] low_word;
    logic [FieldWidth-1:0] high_word;

    assign adv           = !ctl[WIDTH].valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_a          = s_axis_tdata[WIDTH-1:0];
    assign in_b          = s_axis_tdata[FieldWidth+WIDTH-1:FieldWidth];

    always_comb
    begin
        ctl0_next.valid = s_axis_tvalid;
        ctl0_next.kind  = samrd_kind_t'(s_axis_tuser);
        ctl0_next.neg   = in_a[WIDTH-1] ^ in_b[WIDTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (adv)
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo0_reg  <= in_a;
            dvs0_reg  <= in_b;
            mag_a_reg <= in_a[WIDTH-1] ? -in_a : in_a;
            mag_b_reg <= in_b[WIDTH-1] ? -in_b : in_b;
        end
    end

    assign ctl[0] = ctl0_reg;
    assign quo[0] = quo0_reg;
    assign dvs[0] = dvs0_reg;
    assign rem[0] = '0;

    for (genvar i = 1; i <= WIDTH; i++)
    begin : g_stage
        samrd_div_step #(.WIDTH(WIDTH)) u_step
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (ctl[i-1]),
            .quo_in  (quo[i-1]),
            .div_in  (dvs[i-1]),
            .rem_in  (rem[i-1]),
            .ctl_out (ctl[i]),
            .quo_out (quo[i]),
            .div_out (dvs[i]),
            .rem_out (rem[i])
        );

        if (i == 1)
        begin : g_mul
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[i] <= {{WIDTH{1'b0}}, mag_a_reg} * {{WIDTH{1'b0}}, mag_b_reg};
                end
            end
        end
        else if (i == 2)
        begin : g_sign
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[i] <= ctl[i-1].neg ? -prod_reg[i-1] : prod_reg[i-1];
                end
            end
        end
        else
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[i] <= prod_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        if (ctl[WIDTH].kind == KIND_DIV)
        begin
            low_res  = quo[WIDTH];
            high_res = rem[WIDTH];
        end
        else
        begin
            low_res  = prod_reg[WIDTH][WIDTH-1:0];
            high_res = prod_reg[WIDTH][2*WIDTH-1:WIDTH];
        end
    end

    assign low_word      = FieldWidth'(low_res);
    assign high_word     = FieldWidth'(high_res);
    assign m_axis_tvalid = ctl[WIDTH].valid;
    assign m_axis_tdata  = {high_word, low_word};

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ctl[WIDTH].kind == KIND_DIV && dvs[WIDTH] != '0)
        |-> (rem[WIDTH] < dvs[WIDTH]))
        else $error("remainder not below divisor");

    a_zero_div_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ctl[WIDTH].kind == KIND_DIV && dvs[WIDTH] == '0)
        |-> (quo[WIDTH] == '1))
        else $error("zero divisor quotient not all ones");

    a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(quo[WIDTH])))
        else $error("output stage changed during stall");

endmodule

/* rtl/core/samrd_div_step.sv */
// ----------------------------------------------------------------------------
// Restoring division step
// One registered quotient-bit step; the control word passes through.
// ----------------------------------------------------------------------------
module samrd_div_step
    import samrd_pkg::*;
#(
    parameter int unsigned WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  samrd_ctl_t       ctl_in,
    input  logic [WIDTH-1:0] quo_in,
    input  logic [WIDTH-1:0] div_in,
    input  logic [WIDTH-1:0] rem_in,
    output samrd_ctl_t       ctl_out,
    output logic [WIDTH-1:0] quo_out,
    output logic [WIDTH-1:0] div_out,
    output logic [WIDTH-1:0] rem_out
);

    samrd_ctl_t       ctl_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_in, quo_in[WIDTH-1]};
        diff     = trial - {1'b0, div_in};
        fits     = !diff[WIDTH];
        quo_next = {quo_in[WIDTH-2:0], fits};
        rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
            div_reg <= div_in;
            rem_reg <= rem_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;
    assign rem_out = rem_reg;

endmodule

/* tb/tb_shift_add_mul_restoring_div.sv */
// ----------------------------------------------------------------------------
// Testbench for the shift-add multiplier and restoring divider
// Drives signed multiplies and unsigned divides through the stream input,
// predicts each product or quotient and remainder, and compares results in
// order, with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_shift_add_mul_restoring_div;

    timeunit 1ns;
    timeprecision 1ps;

    import samrd_pkg::*;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned LATENCY = WIDTH + 1;

    typedef struct packed
    {
        logic [31:0] high;
        logic [31:0] low;
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // operand_a, operand_b
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // result_low, result_high

    pair_t expected_results[$];
    int    mismatches;
    int    hold_cycles;
    int    hold_requests;
    int    hold_served;
    bit    steady;

    shift_add_mul_restoring_div #(.WIDTH(WIDTH)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic pair_t compute_result(samrd_kind_t kind, logic [31:0] a,
                                             logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [63:0] product;
        logic [32:0] rem;
        logic [31:0] quo;
        pair_t       r;
        if (kind == KIND_MUL)
        begin
            mag_a = a[31] ? -a : a;
            mag_b = b[31] ? -b : b;
            product = 64'd0;
            for (int i = 0; i < WIDTH; i++)
                if (mag_b[i])
                    product += {32'd0, mag_a} << i;
            if (a[31] != b[31])
                product = -product;
            r.low = product[31:0];
            r.high = product[63:32];
        end
        else
        begin
            rem = 33'd0;
            quo = 32'd0;
            for (int i = WIDTH - 1; i >= 0; i--)
            begin
                rem = {rem[31:0], a[i]};
                if (rem >= {1'b0, b})
                begin
                    rem -= {1'b0, b};
                    quo[i] = 1'b1;
                end
            end
            r.low = quo;
            r.high = rem[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic send_operation(samrd_kind_t kind, logic [31:0] a, logic [31:0] b);
        while (!steady && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {b, a};
        expected_results.push_back(compute_result(kind, a, b));
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Ready is driven here; each hold request forces a long stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 0;
            hold_served <= 0;
        end
        else if (hold_requests != hold_served)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 200;
            hold_served <= hold_served + 1;
        end
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            m_axis_tready <= steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        pair_t got;
        pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result_low", got.low, 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.low !== want.low)
                    report_mismatch("result_low", got.low, want.low);
                if (got.high !== want.high)
                    report_mismatch("result_high", got.high, want.high);
            end
        end
    end

    task automatic test_directed();
        logic [31:0] edges[6] = '{32'h0, 32'h1, 32'h7fffffff, 32'h80000000,
                                  32'hffffffff, 32'h80000001};
        for (int i = 0; i < 6; i++)
        begin
            send_operation(KIND_MUL, edges[i], edges[5 - i]);
            send_operation(KIND_DIV, edges[i], edges[(i + 2) % 6]);
        end
        send_operation(KIND_MUL, 32'h80000000, 32'h80000000);
        send_operation(KIND_MUL, 32'hffffffff, 32'hffffffff);
        send_operation(KIND_DIV, 32'hdeadbeef, 32'h0);
        send_operation(KIND_DIV, 32'h0, 32'h0);
        send_operation(KIND_DIV, 32'h12345678, 32'h12345678);
        send_operation(KIND_DIV, 32'h5, 32'hffffffff);
        send_operation(KIND_DIV, 32'hffffffff, 32'h1);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(3))
                0: b = b >> $urandom_range(31);
                1: a = a >> $urandom_range(31);
                default: ;
            endcase
            if ($urandom_range(40) == 0)
                b = 32'd0;
            send_operation(samrd_kind_t'($urandom_range(1)), a, b);
        end
    endtask

    task automatic test_back_pressure();
        hold_requests = hold_requests + 1;
        test_random(80);
        wait_drained();
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        test_random(120);
        steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 64'd0;
        s_axis_tuser = 1'b0;
        mismatches = 0;
        hold_requests = 0;
        steady = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(150);
        wait_drained();
        test_back_pressure();
        test_full_rate();
        test_random(150);
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
